>>> design/ssca_pkg.sv
package ssca_pkg;

    localparam int NUM_CLASSES_D     = 3;
    localparam int PAGE_BYTES_D      = 4096;
    localparam int BASE_CHUNK_D      = 8;
    localparam int GROWTH_D          = 2;
    localparam int TOTAL_PAGES_D     = 4;
    localparam int PAGES_PER_CLASS_D = 16;

    localparam int CMD_W = 1;
    localparam int LEN_W = 12;
    localparam int OFF_W = 14;
    localparam int CLS_W = 2;
    localparam int ST_W  = 3;

    localparam logic [ST_W-1:0] ST_OK      = 3'd0;
    localparam logic [ST_W-1:0] ST_NOPAGE  = 3'd1;
    localparam logic [ST_W-1:0] ST_TOOLONG = 3'd2;
    localparam logic [ST_W-1:0] ST_FOREIGN = 3'd3;
    localparam logic [ST_W-1:0] ST_FULL    = 3'd4;

    localparam logic [CMD_W-1:0] CMD_ALLOC = 1'b0;
    localparam logic [CMD_W-1:0] CMD_FREE  = 1'b1;

    // classified request handed from front to back
    typedef struct packed {
        logic             cmd;
        logic             too_long;
        logic [2:0]       cls;
        logic [OFF_W-1:0] off;
    } t_req;

    // one result beat
    typedef struct packed {
        logic [OFF_W-1:0] off;
        logic [CLS_W-1:0] cls;
        logic [ST_W-1:0]  st;
    } t_rsp;

    // chunk size of a class, widened to 32 bits
    function automatic logic [31:0] chunk_bytes(input int base, input int growth,
                                                input logic [2:0] cls);
        logic [31:0] s;
        s = 32'(base);
        for (int i = 0; i < 8; i++) begin
            if (3'(i) < cls) s = s * 32'(growth);
        end
        return s;
    endfunction

endpackage

>>> design/ssca_ram.sv
module ssca_ram #(
    parameter int WIDTH = 14,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // single write port, registered read
    always_ff @(posedge i_clk) begin
        if (i_we) r_mem[i_waddr] <= i_wdata;
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

>>> design/ssca_front.sv
module ssca_front #(
    parameter int NUM_CLASSES = 3,
    parameter int BASE_CHUNK  = 8,
    parameter int GROWTH      = 2
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    output logic                 o_ready,
    input  logic                 i_cmd,
    input  logic [11:0]          i_value_length,
    input  logic [13:0]          i_chunk_offset,
    output logic                 o_q_valid,
    input  logic                 i_q_ready,
    output ssca_pkg::t_req       o_q_req
);
    import ssca_pkg::*;

    localparam int QD = 2;

    t_req       r_q [QD];
    logic [1:0] r_cnt;
    logic       r_wp, r_rp;
    t_req       n_req;
    logic       push, pop;

    // class pick: first class whose chunk exceeds the length
    always_comb begin
        n_req          = '0;
        n_req.cmd      = i_cmd;
        n_req.off      = i_chunk_offset;
        n_req.too_long = 1'b1;
        for (int c = NUM_CLASSES - 1; c >= 0; c--) begin
            if (chunk_bytes(BASE_CHUNK, GROWTH, 3'(c)) > 32'(i_value_length)) begin
                n_req.cls      = 3'(c);
                n_req.too_long = 1'b0;
            end
        end
    end

    assign o_ready   = (r_cnt != 2'(QD));
    assign push      = i_valid && o_ready;
    assign o_q_valid = (r_cnt != 2'd0);
    assign pop       = o_q_valid && i_q_ready;
    assign o_q_req   = r_q[r_rp];

    // two-entry queue
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
        end else begin
            if (push) r_wp <= ~r_wp;
            if (pop)  r_rp <= ~r_rp;
            r_cnt <= r_cnt + 2'(push) - 2'(pop);
        end
        if (push) r_q[r_wp] <= n_req;
    end
endmodule

>>> design/ssca_back.sv
module ssca_back #(
    parameter int NUM_CLASSES     = 3,
    parameter int PAGE_BYTES      = 4096,
    parameter int BASE_CHUNK      = 8,
    parameter int GROWTH          = 2,
    parameter int TOTAL_PAGES     = 4,
    parameter int PAGES_PER_CLASS = 16
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_q_valid,
    output logic           o_q_ready,
    input  ssca_pkg::t_req i_q_req,
    output logic           o_valid,
    input  logic           i_ready,
    output ssca_pkg::t_rsp o_rsp
);
    import ssca_pkg::*;

    localparam int SDEPTH = (TOTAL_PAGES * PAGE_BYTES) / BASE_CHUNK;
    localparam int SD_W   = $clog2(SDEPTH + 1);
    localparam int MD     = NUM_CLASSES * SDEPTH;
    localparam int MA_W   = $clog2(MD);
    localparam int PG_W   = (TOTAL_PAGES > 1) ? $clog2(TOTAL_PAGES) : 1;
    localparam int CI_W   = (NUM_CLASSES > 1) ? $clog2(NUM_CLASSES) : 1;
    localparam int GV_W   = $clog2(TOTAL_PAGES + 1);
    localparam int CR_W   = $clog2(PAGE_BYTES / BASE_CHUNK + 1);
    localparam int PB_W   = $clog2(PAGE_BYTES);
    localparam logic [2:0] UNOWNED = 3'd7;

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_READ = 2'd1;
    localparam logic [1:0] S_OUT  = 2'd2;

    logic [1:0]      r_state;
    t_req            r_req;
    logic [SD_W-1:0] r_fcnt  [NUM_CLASSES];
    logic [CR_W-1:0] r_carve [NUM_CLASSES];
    logic [PG_W-1:0] r_cpage [NUM_CLASSES];
    logic [2:0]      r_owner [TOTAL_PAGES];
    logic [GV_W-1:0] r_given;
    logic            r_ovalid;
    t_rsp            r_rsp;
    logic            r_was_pop;

    logic            we;
    logic [MA_W-1:0] waddr, raddr;
    logic [OFF_W-1:0] wdata, rdata;

    logic [2:0]      cls;
    logic [CI_W-1:0] ci;
    logic [31:0]     size;
    logic [OFF_W-1:0] page_w;
    logic [6:0]      held;
    logic            fpage_ok;
    logic [2:0]      fcls;
    logic [CI_W-1:0] fci;
    logic [31:0]     fsize;
    logic [OFF_W-1:0] falign;
    logic [31:0]     per_page [NUM_CLASSES];

    // chunks per page of each class, fixed at elaboration
    for (genvar g = 0; g < NUM_CLASSES; g++) begin : g_pp
        localparam int PP = PAGE_BYTES / int'(chunk_bytes(BASE_CHUNK, GROWTH, 3'(g)));
        assign per_page[g] = 32'(PP);
    end

    assign cls  = r_req.cls;
    assign ci   = CI_W'(cls);
    assign size = chunk_bytes(BASE_CHUNK, GROWTH, r_req.cmd ? fcls : cls);
    assign fsize = size;
    assign page_w = r_req.off >> PB_W;
    assign fpage_ok = (32'(page_w) < 32'(r_given)) && (32'(page_w) < 32'(TOTAL_PAGES));
    assign fcls = fpage_ok ? r_owner[PG_W'(page_w)] : UNOWNED;
    assign fci  = (fcls < 3'(NUM_CLASSES)) ? CI_W'(fcls) : '0;
    assign falign = r_req.off & ~OFF_W'(fsize - 32'd1);

    // pages held by the chosen class
    always_comb begin
        held = '0;
        for (int p = 0; p < TOTAL_PAGES; p++)
            if (32'(p) < 32'(r_given) && r_owner[p] == cls) held = held + 7'd1;
    end

    assign raddr = MA_W'(32'(cls) * 32'(SDEPTH) + 32'(r_fcnt[ci] - SD_W'(1)));
    assign waddr = MA_W'(32'(fcls) * 32'(SDEPTH) + 32'(r_fcnt[fci]));
    assign wdata = falign;
    assign we    = (r_state == S_READ) && r_req.cmd && (fcls < 3'(NUM_CLASSES))
                   && (32'(r_fcnt[fci]) < 32'(SDEPTH));

    ssca_ram #(.WIDTH(OFF_W), .DEPTH(MD)) u_ram (
        .i_clk  (i_clk),
        .i_we   (we),
        .i_waddr(waddr),
        .i_wdata(wdata),
        .i_raddr(raddr),
        .o_rdata(rdata)
    );

    assign o_q_ready = (r_state == S_IDLE) && !r_ovalid;
    assign o_valid   = r_ovalid;
    assign o_rsp     = r_rsp;

    // sequencer: take request, read/modify state, present result
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_ovalid <= 1'b0;
            r_given  <= '0;
            for (int c = 0; c < NUM_CLASSES; c++) begin
                r_fcnt[c]  <= '0;
                r_carve[c] <= '0;
                r_cpage[c] <= '0;
            end
            for (int p = 0; p < TOTAL_PAGES; p++) r_owner[p] <= UNOWNED;
        end else begin
            if (r_ovalid && i_ready) r_ovalid <= 1'b0;
            case (r_state)
                S_IDLE: begin
                    if (i_q_valid && o_q_ready) begin
                        r_req   <= i_q_req;
                        r_state <= S_READ;
                    end
                end
                S_READ: begin
                    r_state <= S_OUT;
                    if (r_req.cmd == CMD_FREE) begin
                        if (fcls >= 3'(NUM_CLASSES)) begin
                            r_rsp <= '{off: '0, cls: '0, st: ST_FOREIGN};
                        end else if (32'(r_fcnt[fci]) >= 32'(SDEPTH)) begin
                            r_rsp <= '{off: '0, cls: fcls[1:0], st: ST_FULL};
                        end else begin
                            r_rsp <= '{off: '0, cls: fcls[1:0], st: ST_OK};
                            r_fcnt[fci] <= r_fcnt[fci] + SD_W'(1);
                        end
                    end else if (r_req.too_long) begin
                        r_rsp <= '{off: '0, cls: '0, st: ST_TOOLONG};
                    end else if (r_fcnt[ci] != '0) begin
                        // result offset comes from memory next cycle
                        r_fcnt[ci] <= r_fcnt[ci] - SD_W'(1);
                        r_rsp <= '{off: '0, cls: cls[1:0], st: ST_OK};
                    end else if (r_carve[ci] != '0) begin
                        r_carve[ci] <= r_carve[ci] - CR_W'(1);
                        r_rsp <= '{off: OFF_W'(32'(r_cpage[ci]) * 32'(PAGE_BYTES)
                                       + 32'(r_carve[ci] - CR_W'(1)) * size),
                                   cls: cls[1:0], st: ST_OK};
                    end else if (32'(r_given) >= 32'(TOTAL_PAGES)
                                 || 32'(held) >= 32'(PAGES_PER_CLASS)
                                 || size > 32'(PAGE_BYTES)) begin
                        r_rsp <= '{off: '0, cls: cls[1:0], st: ST_NOPAGE};
                    end else begin
                        r_owner[PG_W'(r_given)] <= cls;
                        r_cpage[ci] <= PG_W'(r_given);
                        r_carve[ci] <= CR_W'(per_page[ci] - 32'd1);
                        r_given <= r_given + GV_W'(1);
                        r_rsp <= '{off: OFF_W'(32'(r_given) * 32'(PAGE_BYTES)
                                       + (per_page[ci] - 32'd1) * size),
                                   cls: cls[1:0], st: ST_OK};
                    end
                end
                S_OUT: begin
                    if (r_req.cmd == CMD_ALLOC && !r_req.too_long
                        && r_rsp.st == ST_OK && r_rsp.off == '0
                        && r_state == S_OUT && r_was_pop)
                        r_rsp.off <= rdata;
                    r_ovalid <= 1'b1;
                    r_state  <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    // marks an allocation served from the freed stack
    always_ff @(posedge i_clk) begin
        if (r_state == S_READ)
            r_was_pop <= (r_req.cmd == CMD_ALLOC) && !r_req.too_long
                         && (r_fcnt[ci] != '0);
    end
endmodule

>>> design/slab_size_class_allocator.sv
// Path from input beat to result valid: front queue, back-end state update, then RAM read.
// The back-end sequencer takes one request at a time, only after the last result is accepted.
// The two-entry front queue accepts new beats while the back end works.
// Reset: synchronous active-low; clears counters, page owners and queues.
// The freed-chunk RAM is not cleared; only entries below each count are read.
module slab_size_class_allocator #(
    parameter int NUM_CLASSES     = ssca_pkg::NUM_CLASSES_D,
    parameter int PAGE_BYTES      = ssca_pkg::PAGE_BYTES_D,
    parameter int BASE_CHUNK      = ssca_pkg::BASE_CHUNK_D,
    parameter int GROWTH          = ssca_pkg::GROWTH_D,
    parameter int TOTAL_PAGES     = ssca_pkg::TOTAL_PAGES_D,
    parameter int PAGES_PER_CLASS = ssca_pkg::PAGES_PER_CLASS_D
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic        i_cmd,
    input  logic [11:0] i_value_length,
    input  logic [13:0] i_chunk_offset,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [13:0] o_result_offset,
    output logic [1:0]  o_size_class,
    output logic [2:0]  o_status
);
    import ssca_pkg::*;

    t_req q_req;
    t_rsp rsp;
    logic q_valid, q_ready;

    ssca_front #(.NUM_CLASSES(NUM_CLASSES), .BASE_CHUNK(BASE_CHUNK), .GROWTH(GROWTH))
    u_front (
        .i_clk, .i_rst_n, .i_valid, .o_ready, .i_cmd, .i_value_length, .i_chunk_offset,
        .o_q_valid(q_valid), .i_q_ready(q_ready), .o_q_req(q_req)
    );

    ssca_back #(
        .NUM_CLASSES(NUM_CLASSES), .PAGE_BYTES(PAGE_BYTES), .BASE_CHUNK(BASE_CHUNK),
        .GROWTH(GROWTH), .TOTAL_PAGES(TOTAL_PAGES), .PAGES_PER_CLASS(PAGES_PER_CLASS)
    ) u_back (
        .i_clk, .i_rst_n, .i_q_valid(q_valid), .o_q_ready(q_ready), .i_q_req(q_req),
        .o_valid, .i_ready, .o_rsp(rsp)
    );

    assign o_result_offset = rsp.off;
    assign o_size_class    = rsp.cls;
    assign o_status        = rsp.st;
endmodule

>>> design/ssca_checker.sv
module ssca_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_valid,
    input logic        o_ready,
    input logic        o_valid,
    input logic        i_ready,
    input logic [13:0] o_result_offset,
    input logic [1:0]  o_size_class,
    input logic [2:0]  o_status
);
    import ssca_pkg::*;

    // result beat holds while stalled
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_result_offset))
        else $error("result changed while stalled");

    // error results carry no offset
    a_err_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_status != ST_OK |-> o_result_offset == '0)
        else $error("error beat with offset");

    // foreign and too-long report class zero
    a_cls_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && (o_status == ST_FOREIGN || o_status == ST_TOOLONG)
        |-> o_size_class == '0)
        else $error("class on classless error");

    // status code in range
    a_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_status <= ST_FULL)
        else $error("bad status");
endmodule

bind slab_size_class_allocator ssca_checker u_chk (.*);

>>> dv/slab_size_class_allocator_tb.sv
module slab_size_class_allocator_tb;
    import ssca_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int STACK_DEPTH = (TOTAL_PAGES_D * PAGE_BYTES_D) / BASE_CHUNK_D;
    localparam int RANDOM_ITEMS = 1880;

    typedef struct {
        logic [OFF_W-1:0] off;
        logic [CLS_W-1:0] cls;
        logic [ST_W-1:0]  st;
    } slab_result_t;

    typedef struct {
        logic [CMD_W-1:0] cmd;
        int               len;
        int               off;
        bit               typed;
        slab_result_t     res;
    } slab_row_t;

    logic             i_clk;
    logic             i_rst_n;
    logic             i_valid;
    logic             o_ready;
    logic             i_cmd;
    logic [11:0]      i_value_length;
    logic [13:0]      i_chunk_offset;
    logic             o_valid;
    logic             i_ready;
    logic [13:0]      o_result_offset;
    logic [1:0]       o_size_class;
    logic [2:0]       o_status;

    // allocator shadow state
    int freed_stack [NUM_CLASSES_D][STACK_DEPTH];
    int freed_cnt   [NUM_CLASSES_D];
    int carve_left  [NUM_CLASSES_D];
    int carve_pg    [NUM_CLASSES_D];
    int page_owner  [TOTAL_PAGES_D];
    int pages_given;

    slab_result_t alloc_expect_q[$];
    int           live_chunks[$];
    int           errors;
    int           beats_in;
    int           beats_out;
    bit           rx_hold_done;
    slab_row_t    dir_rows[$];

    slab_size_class_allocator i_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_valid         (i_valid),
        .o_ready         (o_ready),
        .i_cmd           (i_cmd),
        .i_value_length  (i_value_length),
        .i_chunk_offset  (i_chunk_offset),
        .o_valid         (o_valid),
        .i_ready         (i_ready),
        .o_result_offset (o_result_offset),
        .o_size_class    (o_size_class),
        .o_status        (o_status)
    );

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    initial begin
        #2_000_000;
        $display("CHECK FAILED");
        $finish;
    end

    // works out the result of one request and advances the shadow state
    function automatic slab_result_t slab_predict(logic cmd, logic [11:0] len,
                                                  logic [13:0] off);
        slab_result_t r;
        int c;
        int sz;
        int held;
        int pg;
        r = '{off: '0, cls: '0, st: ST_OK};
        if (cmd == CMD_ALLOC) begin
            if (len < 8) c = 0;
            else if (len < 16) c = 1;
            else if (len < 32) c = 2;
            else begin
                r.st = ST_TOOLONG;
                return r;
            end
            r.cls = CLS_W'(c);
            sz = BASE_CHUNK_D << c;
            if (freed_cnt[c] > 0) begin
                freed_cnt[c]--;
                r.off = OFF_W'(freed_stack[c][freed_cnt[c]]);
                return r;
            end
            if (carve_left[c] == 0) begin
                held = 0;
                for (int p = 0; p < pages_given; p++) if (page_owner[p] == c) held++;
                if (pages_given >= TOTAL_PAGES_D || held >= PAGES_PER_CLASS_D ||
                    PAGE_BYTES_D / sz == 0) begin
                    r.st = ST_NOPAGE;
                    return r;
                end
                page_owner[pages_given] = c;
                carve_pg[c] = pages_given;
                carve_left[c] = PAGE_BYTES_D / sz;
                pages_given++;
            end
            carve_left[c]--;
            r.off = OFF_W'(carve_pg[c] * PAGE_BYTES_D + carve_left[c] * sz);
        end else begin
            pg = off / PAGE_BYTES_D;
            if (pg >= pages_given || page_owner[pg] >= NUM_CLASSES_D) begin
                r.st = ST_FOREIGN;
                return r;
            end
            c = page_owner[pg];
            r.cls = CLS_W'(c);
            if (freed_cnt[c] >= STACK_DEPTH) begin
                r.st = ST_FULL;
                return r;
            end
            sz = BASE_CHUNK_D << c;
            freed_stack[c][freed_cnt[c]] = pg * PAGE_BYTES_D + ((off % PAGE_BYTES_D) / sz) * sz;
            freed_cnt[c]++;
        end
        return r;
    endfunction

    // offer one request beat; predict once it is taken
    task automatic offer_request(logic cmd, int len, int off, bit typed, slab_result_t tres,
                                 bit steady);
        slab_result_t r;
        while (!steady && $urandom_range(0, 99) < 6) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid        <= 1'b1;
        i_cmd          <= cmd;
        i_value_length <= len[11:0];
        i_chunk_offset <= off[13:0];
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
        r = slab_predict(cmd, len[11:0], off[13:0]);
        if (cmd == CMD_ALLOC && r.st == ST_OK) live_chunks.push_back(int'(r.off));
        alloc_expect_q.push_back(typed ? tres : r);
        beats_in++;
    endtask

    task automatic drain_results();
        i_valid <= 1'b0;
        while (alloc_expect_q.size() != 0) @(posedge i_clk);
        repeat (10) @(posedge i_clk);
    endtask

    // result beats: compare with the oldest expectation
    always @(posedge i_clk) begin
        slab_result_t e;
        if (i_rst_n && o_valid && i_ready) begin
            beats_out++;
            if (alloc_expect_q.size() == 0) begin
                $display("%0t: unexpected result off=%0d cls=%0d st=%0d", $time,
                         o_result_offset, o_size_class, o_status);
                errors++;
            end else begin
                e = alloc_expect_q.pop_front();
                if (o_result_offset !== e.off || o_size_class !== e.cls ||
                    o_status !== e.st) begin
                    $display("%0t: expected off=%0d cls=%0d st=%0d, got off=%0d cls=%0d st=%0d",
                             $time, e.off, e.cls, e.st, o_result_offset, o_size_class,
                             o_status);
                    errors++;
                end
            end
        end
    end

    // receiver: random back-pressure, one long hold-off, a quiet stretch
    initial begin
        int hold;
        hold = 0;
        rx_hold_done = 1'b0;
        i_ready = 1'b0;
        forever begin
            @(posedge i_clk);
            if (!rx_hold_done && beats_out >= 300) begin
                rx_hold_done = 1'b1;
                hold = 200;
            end
            if (hold > 0) begin
                hold--;
                i_ready <= 1'b0;
            end else if (beats_out >= 900 && beats_out < 1200) begin
                i_ready <= 1'b1;
            end else begin
                i_ready <= ($urandom_range(0, 99) >= 6);
            end
        end
    end

    initial begin
        slab_result_t none;
        int k;
        int r;
        int len;
        int off;
        logic cmd;
        none = '{off: '0, cls: '0, st: ST_OK};
        errors = 0;
        beats_in = 0;
        beats_out = 0;
        for (int c = 0; c < NUM_CLASSES_D; c++) begin
            freed_cnt[c] = 0;
            carve_left[c] = 0;
            carve_pg[c] = 0;
        end
        for (int p = 0; p < TOTAL_PAGES_D; p++) page_owner[p] = 7;
        pages_given = 0;
        i_rst_n = 1'b0;
        i_valid = 1'b0;
        i_cmd = CMD_ALLOC;
        i_value_length = '0;
        i_chunk_offset = '0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed rows: foreign frees, too long, carve order, misaligned and double free
        dir_rows = '{
            '{CMD_FREE,  0,    0,     1, '{0,     0, ST_FOREIGN}},
            '{CMD_ALLOC, 4095, 0,     1, '{0,     0, ST_TOOLONG}},
            '{CMD_ALLOC, 0,    0,     1, '{4088,  0, ST_OK}},
            '{CMD_ALLOC, 7,    0,     1, '{4080,  0, ST_OK}},
            '{CMD_ALLOC, 8,    0,     1, '{8176,  1, ST_OK}},
            '{CMD_ALLOC, 31,   0,     1, '{12256, 2, ST_OK}},
            '{CMD_ALLOC, 32,   16383, 1, '{0,     0, ST_TOOLONG}},
            '{CMD_FREE,  0,    16383, 1, '{0,     0, ST_FOREIGN}},
            '{CMD_FREE,  4095, 4089,  1, '{0,     0, ST_OK}},
            '{CMD_ALLOC, 1,    0,     0, none},
            '{CMD_FREE,  0,    8177,  0, none},
            '{CMD_FREE,  0,    8191,  0, none},
            '{CMD_ALLOC, 15,   0,     0, none},
            '{CMD_ALLOC, 15,   0,     0, none},
            '{CMD_ALLOC, 16,   0,     0, none},
            '{CMD_FREE,  0,    12287, 0, none},
            '{CMD_ALLOC, 20,   0,     0, none},
            '{CMD_FREE,  0,    12286, 0, none},
            '{CMD_ALLOC, 16,   8192,  0, none}
        };
        foreach (dir_rows[i])
            offer_request(dir_rows[i].cmd, dir_rows[i].len, dir_rows[i].off,
                          dir_rows[i].typed, dir_rows[i].res, 1'b0);

        // random mix: alloc-heavy early so the pages run out, then balanced
        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            cmd = ($urandom_range(0, 99) < (n < 600 ? 85 : 50)) ? CMD_ALLOC : CMD_FREE;
            r = $urandom_range(0, 99);
            if (cmd == CMD_ALLOC) begin
                if (r < 80) len = $urandom_range(0, 31);
                else if (r < 90) len = $urandom_range(32, 4095);
                else len = $urandom_range(0, 4095);
                off = $urandom_range(0, 16383);
            end else begin
                len = $urandom_range(0, 4095);
                if (r < 75 && live_chunks.size() != 0) begin
                    k = $urandom_range(0, live_chunks.size() - 1);
                    off = live_chunks[k];
                    if ($urandom_range(0, 3) == 0) off += $urandom_range(0, 7);
                    if ($urandom_range(0, 4) != 0) live_chunks.delete(k);
                end else begin
                    off = $urandom_range(0, 16383);
                end
            end
            offer_request(cmd, len, off, 1'b0, none, n >= 900 && n < 1200);
        end
        drain_results();

        if (errors == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule
